@@ src/pit_pkg.sv @@
// ---------------------------------------------------------------------------
// pit_pkg: shared types and constants for the point-in-triangle test unit
// Coordinate and intermediate widths, vector types and pipeline stage indexes.
// ---------------------------------------------------------------------------
package pit_pkg;

    // Coordinate width of every input field
    localparam int COORD_WIDTH = 16;

    // Widths of the exact intermediate values
    localparam int DIFF_W   = COORD_WIDTH + 1;      // vertex difference
    localparam int PROD_W   = 2 * DIFF_W;           // difference times difference
    localparam int CROSS_W  = PROD_W + 1;           // cross product component
    localparam int LO_W     = (CROSS_W + 1) / 2;    // low split of a cross component
    localparam int HI_W     = CROSS_W - LO_W;       // high split of a cross component
    localparam int PL_W     = CROSS_W + LO_W + 1;   // partial product, low half
    localparam int PH_W     = CROSS_W + HI_W;       // partial product, high half
    localparam int DOTP_W   = 2 * CROSS_W;          // full product of cross components
    localparam int DOT_W    = DOTP_W + 2;           // sum of three full products
    localparam int NP_W     = CROSS_W + DIFF_W;     // normal times offset
    localparam int NDOT_W   = NP_W + 2;             // coplanarity sum

    localparam int NUM_TESTS  = 3;
    localparam int NUM_STAGES = 6;

    // Pipeline stage indexes
    localparam int ST_DIFF = 0;     // vertex differences
    localparam int ST_XMUL = 1;     // cross product terms
    localparam int ST_XSUB = 2;     // cross product components
    localparam int ST_DMUL = 3;     // dot product partial products
    localparam int ST_DSUM = 4;     // full products, coplanarity sum
    localparam int ST_OUT  = 5;     // sign tests, result register

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    // Vectors: element 0 is x, 1 is y, 2 is z
    typedef logic [2:0][COORD_WIDTH-1:0] t_pvec;
    typedef logic [2:0][DIFF_W-1:0]      t_dvec;
    typedef logic [2:0][CROSS_W-1:0]     t_cvec;

    // Per-stage load enables
    typedef logic [NUM_STAGES-1:0] t_stage_en;

endpackage

@@ src/pit_if.sv @@
// ---------------------------------------------------------------------------
// pit_if: valid/ready channels of the point-in-triangle test unit
// Input word carries the point and three vertices; output word the verdict.
// ---------------------------------------------------------------------------
interface pit_in_if;
    import pit_pkg::*;

    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    t_coord point_z;
    t_coord a_x;
    t_coord a_y;
    t_coord a_z;
    t_coord b_x;
    t_coord b_y;
    t_coord b_z;
    t_coord c_x;
    t_coord c_y;
    t_coord c_z;

    modport source (
        output valid, point_x, point_y, point_z, a_x, a_y, a_z,
               b_x, b_y, b_z, c_x, c_y, c_z,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z, a_x, a_y, a_z,
               b_x, b_y, b_z, c_x, c_y, c_z,
        output ready
    );
endinterface

interface pit_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic degenerate;

    modport source (output valid, inside_res, degenerate, input ready);
    modport sink   (input valid, inside_res, degenerate, output ready);
endinterface

@@ src/pit_diff.sv @@
// ---------------------------------------------------------------------------
// pit_diff: first pipeline stage
// Registers the six vertex difference vectors used by the edge tests.
// ---------------------------------------------------------------------------
module pit_diff (
    input  logic              i_clk,
    input  logic              i_en,
    input  pit_pkg::t_pvec    i_p,
    input  pit_pkg::t_pvec    i_a,
    input  pit_pkg::t_pvec    i_b,
    input  pit_pkg::t_pvec    i_c,
    output pit_pkg::t_dvec    o_cb,
    output pit_pkg::t_dvec    o_pb,
    output pit_pkg::t_dvec    o_ab,
    output pit_pkg::t_dvec    o_ca,
    output pit_pkg::t_dvec    o_pa,
    output pit_pkg::t_dvec    o_ba
);
    import pit_pkg::*;

    t_dvec r_cb, r_pb, r_ab, r_ca, r_pa, r_ba;

    // Sign-extended differences, one per component
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_cb[k] <= DIFF_W'($signed(i_c[k])) - DIFF_W'($signed(i_b[k]));
                r_pb[k] <= DIFF_W'($signed(i_p[k])) - DIFF_W'($signed(i_b[k]));
                r_ab[k] <= DIFF_W'($signed(i_a[k])) - DIFF_W'($signed(i_b[k]));
                r_ca[k] <= DIFF_W'($signed(i_c[k])) - DIFF_W'($signed(i_a[k]));
                r_pa[k] <= DIFF_W'($signed(i_p[k])) - DIFF_W'($signed(i_a[k]));
                r_ba[k] <= DIFF_W'($signed(i_b[k])) - DIFF_W'($signed(i_a[k]));
            end
        end
    end

    assign o_cb = r_cb;
    assign o_pb = r_pb;
    assign o_ab = r_ab;
    assign o_ca = r_ca;
    assign o_pa = r_pa;
    assign o_ba = r_ba;

endmodule

@@ src/pit_cross.sv @@
// ---------------------------------------------------------------------------
// pit_cross: two-stage cross product of two difference vectors
// Stage one registers the six products, stage two their differences.
// ---------------------------------------------------------------------------
module pit_cross (
    input  logic                i_clk,
    input  pit_pkg::t_stage_en  i_en,
    input  pit_pkg::t_dvec      i_u,
    input  pit_pkg::t_dvec      i_v,
    output pit_pkg::t_cvec      o_c
);
    import pit_pkg::*;

    logic signed [PROD_W-1:0] r_p [3];
    logic signed [PROD_W-1:0] r_q [3];
    t_cvec                    r_c;

    // Product terms: c[k] = p[k] - q[k]
    always_ff @(posedge i_clk) begin
        if (i_en[ST_XMUL]) begin
            r_p[0] <= $signed(i_u[1]) * $signed(i_v[2]);
            r_q[0] <= $signed(i_v[1]) * $signed(i_u[2]);
            r_p[1] <= $signed(i_u[2]) * $signed(i_v[0]);
            r_q[1] <= $signed(i_v[2]) * $signed(i_u[0]);
            r_p[2] <= $signed(i_u[0]) * $signed(i_v[1]);
            r_q[2] <= $signed(i_v[0]) * $signed(i_u[1]);
        end
    end

    // Components
    always_ff @(posedge i_clk) begin
        if (i_en[ST_XSUB]) begin
            for (int k = 0; k < 3; k++) begin
                r_c[k] <= CROSS_W'(r_p[k]) - CROSS_W'(r_q[k]);
            end
        end
    end

    assign o_c = r_c;

endmodule

@@ src/pit_dot.sv @@
// ---------------------------------------------------------------------------
// pit_dot: dot product signs and final verdict
// Three same-side dot products (split multiplies), coplanarity and degeneracy.
// ---------------------------------------------------------------------------
module pit_dot (
    input  logic                i_clk,
    input  pit_pkg::t_stage_en  i_en,
    input  pit_pkg::t_cvec      i_s [pit_pkg::NUM_TESTS],
    input  pit_pkg::t_cvec      i_t [pit_pkg::NUM_TESTS],
    input  pit_pkg::t_cvec      i_n,
    input  pit_pkg::t_dvec      i_d,
    output logic                o_inside_res,
    output logic                o_degenerate
);
    import pit_pkg::*;

    logic signed [PL_W-1:0]   r_pl    [NUM_TESTS][3];
    logic signed [PH_W-1:0]   r_ph    [NUM_TESTS][3];
    logic signed [NP_W-1:0]   r_np    [3];
    logic                     r_degen_mul;
    logic signed [DOTP_W-1:0] r_pf    [NUM_TESTS][3];
    logic signed [NDOT_W-1:0] r_nsum;
    logic                     r_degen_sum;
    logic                     r_inside;
    logic                     r_degen_out;

    logic signed [DOT_W-1:0]  dot_sum [NUM_TESTS];
    logic                     prism;

    // Partial products: second operand split into unsigned low and signed high
    always_ff @(posedge i_clk) begin
        if (i_en[ST_DMUL]) begin
            for (int i = 0; i < NUM_TESTS; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_pl[i][k] <= $signed(i_s[i][k])
                                * $signed({1'b0, i_t[i][k][LO_W-1:0]});
                    r_ph[i][k] <= $signed(i_s[i][k])
                                * $signed(i_t[i][k][CROSS_W-1:LO_W]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                r_np[k] <= $signed(i_n[k]) * $signed(i_d[k]);
            end
            r_degen_mul <= (i_n == '0);
        end
    end

    // Recombine full products; coplanarity sum
    always_ff @(posedge i_clk) begin
        if (i_en[ST_DSUM]) begin
            for (int i = 0; i < NUM_TESTS; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_pf[i][k] <= (DOTP_W'(r_ph[i][k]) <<< LO_W) + DOTP_W'(r_pl[i][k]);
                end
            end
            r_nsum      <= NDOT_W'(r_np[0]) + NDOT_W'(r_np[1]) + NDOT_W'(r_np[2]);
            r_degen_sum <= r_degen_mul;
        end
    end

    // Same-side sums and their signs
    always_comb begin
        prism = 1'b1;
        for (int i = 0; i < NUM_TESTS; i++) begin
            dot_sum[i] = DOT_W'(r_pf[i][0]) + DOT_W'(r_pf[i][1]) + DOT_W'(r_pf[i][2]);
            prism      = prism && !dot_sum[i][DOT_W-1];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_en[ST_OUT]) begin
            r_inside    <= prism && !r_degen_sum && (r_nsum == '0);
            r_degen_out <= r_degen_sum;
        end
    end

    assign o_inside_res = r_inside;
    assign o_degenerate = r_degen_out;

endmodule

@@ src/point_in_triangle_test_unit.sv @@
// ---------------------------------------------------------------------------
// point_in_triangle_test_unit: 3D point-in-triangle test, exact integers
// Three same-side edge tests plus a coplanarity test on a six-stage pipeline.
// ---------------------------------------------------------------------------
//  channel | dir | handshake     | word
//  --------+-----+---------------+-------------------------------------------
//  i_in    | in  | valid / ready | point_x..z, a_x..z, b_x..z, c_x..z
//  o_out   | out | valid / ready | inside_res, degenerate
//
//  One word per cycle while o_out does not stall; six register stages
//  (differences, two cross stages, three dot stages) lie between the
//  accepting edge and o_out.valid.
//  Each stage loads when it is empty or the stage after it moves, so a
//  stalled output backs up only as far as the first empty stage.
//  i_in.ready is low only when all six stages hold words and o_out stalls.
//  Reset clears the stage valid bits; data registers are not reset.
// ---------------------------------------------------------------------------
module point_in_triangle_test_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pit_in_if.sink      i_in,
    pit_out_if.source   o_out
);
    import pit_pkg::*;

    t_stage_en          r_vld;
    t_stage_en          stage_en;

    t_pvec              in_p, in_a, in_b, in_c;
    t_dvec              d_cb, d_pb, d_ab, d_ca, d_pa, d_ba;
    t_dvec              r_d_xmul, r_d_xsub;
    t_cvec              x_s [NUM_TESTS];
    t_cvec              x_t [NUM_TESTS];
    logic               res_inside, res_degen;
    logic               in_acc, out_acc;

    // Stage enables, back to front
    always_comb begin
        stage_en[ST_OUT] = !r_vld[ST_OUT] || o_out.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[ST_DIFF]) begin
                r_vld[ST_DIFF] <= i_in.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready = stage_en[ST_DIFF];

    // Input word as vectors
    assign in_p = {i_in.point_z, i_in.point_y, i_in.point_x};
    assign in_a = {i_in.a_z, i_in.a_y, i_in.a_x};
    assign in_b = {i_in.b_z, i_in.b_y, i_in.b_x};
    assign in_c = {i_in.c_z, i_in.c_y, i_in.c_x};

    pit_diff u_diff (
        .i_clk  (i_clk),
        .i_en   (stage_en[ST_DIFF]),
        .i_p    (in_p),
        .i_a    (in_a),
        .i_b    (in_b),
        .i_c    (in_c),
        .o_cb   (d_cb),
        .o_pb   (d_pb),
        .o_ab   (d_ab),
        .o_ca   (d_ca),
        .o_pa   (d_pa),
        .o_ba   (d_ba)
    );

    // Offset P-A follows the cross stages for the coplanarity dot
    always_ff @(posedge i_clk) begin
        if (stage_en[ST_XMUL]) begin
            r_d_xmul <= d_pa;
        end
        if (stage_en[ST_XSUB]) begin
            r_d_xsub <= r_d_xmul;
        end
    end

    // Edge B->C, opposite vertex A
    pit_cross u_cross_bc_p (.i_clk(i_clk), .i_en(stage_en), .i_u(d_cb), .i_v(d_pb),
                            .o_c(x_s[0]));
    pit_cross u_cross_bc_q (.i_clk(i_clk), .i_en(stage_en), .i_u(d_cb), .i_v(d_ab),
                            .o_c(x_t[0]));
    // Edge A->C, opposite vertex B
    pit_cross u_cross_ac_p (.i_clk(i_clk), .i_en(stage_en), .i_u(d_ca), .i_v(d_pa),
                            .o_c(x_s[1]));
    pit_cross u_cross_ac_q (.i_clk(i_clk), .i_en(stage_en), .i_u(d_ca), .i_v(d_ba),
                            .o_c(x_t[1]));
    // Edge A->B, opposite vertex C; its second cross is the triangle normal
    pit_cross u_cross_ab_p (.i_clk(i_clk), .i_en(stage_en), .i_u(d_ba), .i_v(d_pa),
                            .o_c(x_s[2]));
    pit_cross u_cross_ab_q (.i_clk(i_clk), .i_en(stage_en), .i_u(d_ba), .i_v(d_ca),
                            .o_c(x_t[2]));

    pit_dot u_dot (
        .i_clk        (i_clk),
        .i_en         (stage_en),
        .i_s          (x_s),
        .i_t          (x_t),
        .i_n          (x_t[2]),
        .i_d          (r_d_xsub),
        .o_inside_res (res_inside),
        .o_degenerate (res_degen)
    );

    assign o_out.valid      = r_vld[ST_OUT];
    assign o_out.inside_res = res_inside;
    assign o_out.degenerate = res_degen;

    // Checks
    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    a_degen_not_inside : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.degenerate) |-> !o_out.inside_res)
        else $error("degenerate triangle reported inside");

    a_ready_when_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld != '1) |-> i_in.ready)
        else $error("input stalled with an empty stage");

    a_no_bubble_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_OUT-1] && stage_en[ST_OUT-1]) |=> r_vld[ST_OUT])
        else $error("word lost entering the output stage");

    a_occupancy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (int'($countones(r_vld)) == int'($countones($past(r_vld)))
            + int'($past(in_acc)) - int'($past(out_acc))))
        else $error("pipeline occupancy does not match accepted words");

endmodule

@@ tb/pit_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pit_checker: verdict predictor and scoreboard for the point-in-triangle unit
// Watches both channels. Each accepted input word is run through an exact
// integer model of the same-side and coplanarity tests. Each accepted output
// word is compared against the oldest pending verdict.
// ---------------------------------------------------------------------------
module pit_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pit_in_if       i_in_mon,
    pit_out_if      i_out_mon,
    output int      o_fail_count,
    output int      o_pending
);
    import pit_pkg::*;

    // Wide enough for a dot product of two cross products, with margin
    typedef logic signed [127:0] t_wide;
    typedef struct packed {
        longint x;
        longint y;
        longint z;
    } t_ivec;
    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } t_verdict;

    t_verdict verdict_q[$];

    function automatic t_ivec widen(t_pvec v);
        t_ivec r;
        r.x = longint'($signed(v[0]));
        r.y = longint'($signed(v[1]));
        r.z = longint'($signed(v[2]));
        return r;
    endfunction

    function automatic t_ivec vec_diff(t_ivec u, t_ivec v);
        t_ivec r;
        r.x = u.x - v.x;
        r.y = u.y - v.y;
        r.z = u.z - v.z;
        return r;
    endfunction

    // Components stay within 35 bits, so longint is exact here
    function automatic t_ivec vec_cross(t_ivec u, t_ivec v);
        t_ivec r;
        r.x = u.y * v.z - v.y * u.z;
        r.y = u.z * v.x - v.z * u.x;
        r.z = u.x * v.y - v.x * u.y;
        return r;
    endfunction

    function automatic t_wide dot_exact(t_ivec u, t_ivec v);
        return t_wide'(u.x) * t_wide'(v.x) + t_wide'(u.y) * t_wide'(v.y)
             + t_wide'(u.z) * t_wide'(v.z);
    endfunction

    // P and Q on the same side of edge E0-E1 (zero counts as same side)
    function automatic bit same_side(t_ivec p, t_ivec q, t_ivec e0, t_ivec e1);
        t_ivec edge_v;
        edge_v = vec_diff(e1, e0);
        return dot_exact(vec_cross(edge_v, vec_diff(p, e0)),
                         vec_cross(edge_v, vec_diff(q, e0))) >= 0;
    endfunction

    function automatic t_verdict predict_verdict(t_pvec pp, t_pvec pa, t_pvec pb,
                                                 t_pvec pc);
        t_ivec    p, a, b, c, nrm;
        bit       prism, degen, coplanar;
        t_verdict r;
        p = widen(pp);
        a = widen(pa);
        b = widen(pb);
        c = widen(pc);
        prism = same_side(p, a, b, c) && same_side(p, b, a, c) &&
                same_side(p, c, a, b);
        nrm = vec_cross(vec_diff(b, a), vec_diff(c, a));
        degen = (nrm.x == 0) && (nrm.y == 0) && (nrm.z == 0);
        coplanar = dot_exact(nrm, vec_diff(p, a)) == 0;
        r.inside_res = prism && !degen && coplanar;
        r.degenerate = degen;
        return r;
    endfunction

    // Scoreboard: compare outputs first so an early word is never masked
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (!i_rst_n) begin
            verdict_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (verdict_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: output word with no verdict pending", $realtime);
                    o_fail_count++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (i_out_mon.inside_res !== exp_v.inside_res ||
                        i_out_mon.degenerate !== exp_v.degenerate) begin
                        if (o_fail_count < 10)
                            $display("%0t: mismatch: expected inside/degen %0b/%0b, got %0b/%0b",
                                     $realtime, exp_v.inside_res, exp_v.degenerate,
                                     i_out_mon.inside_res, i_out_mon.degenerate);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                verdict_q.push_back(predict_verdict(
                    {i_in_mon.point_z, i_in_mon.point_y, i_in_mon.point_x},
                    {i_in_mon.a_z, i_in_mon.a_y, i_in_mon.a_x},
                    {i_in_mon.b_z, i_in_mon.b_y, i_in_mon.b_x},
                    {i_in_mon.c_z, i_in_mon.c_y, i_in_mon.c_x}));
        end
        o_pending = verdict_q.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: stimulus and verdict for the point-in-triangle test unit
// Directed corner words, then random triangles built on integer lattices so
// that many points land exactly in plane and inside, plus degenerate and
// fully random words in three phases. Sender and receiver idle at random in
// the first two; one long receiver hold-off backs the pipeline up into the input.
// ---------------------------------------------------------------------------
module tb_top;
    import pit_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int WORDS_PER_PHASE = 400;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_cnt;
    int   tx_idle_pct;
    int   rx_idle_pct;
    bit   hold_start;

    pit_in_if  in_ch ();
    pit_out_if out_ch ();

    point_in_triangle_test_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pit_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic t_pvec mk(int x, int y, int z);
        return {COORD_WIDTH'(z), COORD_WIDTH'(y), COORD_WIDTH'(x)};
    endfunction

    // Offer one word, idling first at random, and wait until it is taken
    task automatic send_word(input t_pvec p, input t_pvec a, input t_pvec b,
                             input t_pvec c);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.point_x <= p[0];
        in_ch.point_y <= p[1];
        in_ch.point_z <= p[2];
        in_ch.a_x     <= a[0];
        in_ch.a_y     <= a[1];
        in_ch.a_z     <= a[2];
        in_ch.b_x     <= b[0];
        in_ch.b_y     <= b[1];
        in_ch.b_z     <= b[2];
        in_ch.c_x     <= c[0];
        in_ch.c_y     <= c[1];
        in_ch.c_z     <= c[2];
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Random word: lattice triangles (in plane, off plane, degenerate)
    // or fully random coordinates
    task automatic send_random_word();
        int    kind, span, mmax, m, n, s, t, k;
        int    ax, ay, az, ux, uy, uz, vx, vy, vz, px, py, pz;
        t_pvec a, b, c, p;
        kind = $urandom_range(99);
        if (kind < 30) begin
            send_word(t_pvec'($urandom), t_pvec'({$urandom, $urandom}),
                      t_pvec'({$urandom, $urandom}), t_pvec'({$urandom, $urandom}));
        end else begin
            // Either long steps few times, or short steps many times
            span = ($urandom_range(3) == 0) ? 2000 : 200;
            mmax = (span == 2000) ? 6 : 60;
            ax = $urandom_range(16000) - 8000;
            ay = $urandom_range(16000) - 8000;
            az = $urandom_range(16000) - 8000;
            ux = $urandom_range(2 * span) - span;
            uy = $urandom_range(2 * span) - span;
            uz = $urandom_range(2 * span) - span;
            vx = $urandom_range(2 * span) - span;
            vy = $urandom_range(2 * span) - span;
            vz = $urandom_range(2 * span) - span;
            m = $urandom_range(mmax, 1);
            n = $urandom_range(mmax, 1);
            s = $urandom_range(m + m / 2) - m / 2;
            t = $urandom_range(n + n / 2) - n / 2;
            // Collinear third vertex makes the triangle degenerate
            if (kind >= 90) begin
                vx = ux;
                vy = uy;
                vz = uz;
            end
            px = ax + s * ux + t * vx;
            py = ay + s * uy + t * vy;
            pz = az + s * uz + t * vz;
            // Nudge one coordinate off the plane
            if (kind >= 75 && kind < 90) begin
                k = $urandom_range(2);
                if (k == 0) px += ($urandom_range(1) != 0) ? 1 : -1;
                else if (k == 1) py += ($urandom_range(1) != 0) ? 1 : -1;
                else pz += ($urandom_range(1) != 0) ? 1 : -1;
            end
            a = mk(ax, ay, az);
            b = mk(ax + m * ux, ay + m * uy, az + m * uz);
            c = mk(ax + n * vx, ay + n * vy, az + n * vz);
            p = mk(px, py, pz);
            // Sometimes repeat a vertex
            if (kind >= 97)
                b = a;
            send_word(p, a, b, c);
        end
    endtask

    // Stimulus and verdict
    initial begin
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.point_x <= '0;
        in_ch.point_y <= '0;
        in_ch.point_z <= '0;
        in_ch.a_x     <= '0;
        in_ch.a_y     <= '0;
        in_ch.a_z     <= '0;
        in_ch.b_x     <= '0;
        in_ch.b_y     <= '0;
        in_ch.b_z     <= '0;
        in_ch.c_x     <= '0;
        in_ch.c_y     <= '0;
        in_ch.c_z     <= '0;
        hold_start    = 1'b0;
        tx_idle_pct   = 27;
        rx_idle_pct   = 69;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: basic inside, outside, off plane, edge and vertex points
        send_word(mk(0, 0, 0), mk(0, 0, 0), mk(0, 0, 0), mk(0, 0, 0));
        send_word(mk(2, 2, 0), mk(0, 0, 0), mk(10, 0, 0), mk(0, 10, 0));
        send_word(mk(20, 20, 0), mk(0, 0, 0), mk(10, 0, 0), mk(0, 10, 0));
        send_word(mk(2, 2, 1), mk(0, 0, 0), mk(10, 0, 0), mk(0, 10, 0));
        send_word(mk(5, 0, 0), mk(0, 0, 0), mk(10, 0, 0), mk(0, 10, 0));
        send_word(mk(0, 0, 0), mk(0, 0, 0), mk(10, 0, 0), mk(0, 10, 0));
        send_word(mk(0, 10, 0), mk(0, 0, 0), mk(10, 0, 0), mk(0, 10, 0));
        send_word(mk(0, -1, 0), mk(0, 0, 0), mk(10, 0, 0), mk(0, 10, 0));
        send_word(mk(3, 3, 0), mk(0, 0, 0), mk(0, 10, 0), mk(10, 0, 0));
        // Triangle in the yz plane
        send_word(mk(0, 30, 30), mk(0, 0, 0), mk(0, 100, 0), mk(0, 0, 100));
        send_word(mk(-1, 30, 30), mk(0, 0, 0), mk(0, 100, 0), mk(0, 0, 100));
        // Degenerate: collinear vertices, repeated vertex
        send_word(mk(1, 1, 1), mk(0, 0, 0), mk(1, 1, 1), mk(2, 2, 2));
        send_word(mk(4, 5, 6), mk(7, 8, 9), mk(7, 8, 9), mk(1, 2, 3));
        // Full-range triangles
        send_word(mk(0, 0, 0), mk(-32768, -32768, 0), mk(32767, -32768, 0),
                  mk(0, 32767, 0));
        send_word(mk(-32768, 32767, 0), mk(-32768, -32768, 0), mk(32767, -32768, 0),
                  mk(0, 32767, 0));
        send_word(mk(-32768, -32768, -32768), mk(-32768, -32768, -32768),
                  mk(32767, 32767, 32767), mk(32767, -32768, 32767));
        send_word(mk(32767, 32767, 32767), mk(-32768, -32768, -32768),
                  mk(32767, -32768, 32767), mk(-32768, 32767, 32767));
        send_word(mk(-32768, -32768, -32768), mk(-32768, -32768, -32768),
                  mk(-32768, -32768, -32768), mk(-32768, -32768, -32768));
        send_word(mk(32767, 32767, 32767), mk(32767, 32767, 32767),
                  mk(32767, 32767, 32767), mk(32767, 32767, 32767));
        // Alternating bit patterns
        send_word(mk(16'h5555, 16'hAAAA, 16'h5555), mk(16'hAAAA, 16'h5555, 16'hAAAA),
                  mk(16'h5555, 16'h5555, 16'hAAAA), mk(16'hAAAA, 16'hAAAA, 16'h5555));

        // Phase 1: sender idles lightly, receiver heavily
        repeat (WORDS_PER_PHASE) send_random_word();

        // Phase 2: the other way round
        tx_idle_pct = 69;
        rx_idle_pct = 27;
        repeat (WORDS_PER_PHASE) send_random_word();

        // Phase 3: no idling; starts with a long receiver hold-off so the
        // pipeline fills and stalls the input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_start  = 1'b1;
        repeat (40 + WORDS_PER_PHASE) send_random_word();
        in_ch.valid <= 1'b0;

        // Drain, then allow for the pipeline latency
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
